// ===== rtl/fem_shape_function_eval_assert.svh =====
// Assertion macros used by the back end of the shape function evaluator RTL.
`ifndef FEM_SHAPE_FUNCTION_EVAL_ASSERT_SVH
`define FEM_SHAPE_FUNCTION_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fse_pkg.sv =====
// Shared constants and types of the shape function evaluator.
package fse_pkg;

  localparam int FRAC_BITS_DFLT = 14;
  localparam int PT_DEPTH_DFLT  = 4;
  localparam int RES_DEPTH_DFLT = 8;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 22;
  localparam int OUT_W   = 18;
  localparam int NODE_W  = 3;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_TRI       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUAD4     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUAD8     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUAD8_ALT = 2'd3;
  localparam logic [KIND_W-1:0] KIND_RESET     = KIND_QUAD8;

  localparam logic [NODE_W-1:0] LAST_TRI   = 3'd2;
  localparam logic [NODE_W-1:0] LAST_QUAD4 = 3'd3;
  localparam logic [NODE_W-1:0] LAST_QUAD8 = 3'd7;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  typedef struct packed {
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] eta;
    logic        [SQ_W-1:0]    xx;
    logic        [SQ_W-1:0]    ee;
    logic        [KIND_W-1:0]  kind;
    logic        [NODE_W-1:0]  last_nd;
  } pt_t;

  typedef struct packed {
    logic        [NODE_W-1:0] node;
    logic signed [OUT_W-1:0]  shape;
    logic signed [OUT_W-1:0]  dxi;
    logic signed [OUT_W-1:0]  deta;
    logic                     last;
  } res_t;

endpackage

// ===== rtl/fse_fifo.sv =====
// Small first-in first-out queue built from registers.
module fse_fifo import fse_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = PT_DEPTH_DFLT,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fse_front.sv =====
// Front end: element kind register, point intake, squares and classification.
module fse_front import fse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [KIND_W-1:0]         cfg_element_kind,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic signed [COORD_W-1:0] in_xi_coord,
  input  logic signed [COORD_W-1:0] in_eta_coord,
  input  logic                      q_full,
  output logic                      q_push,
  output pt_t                       q_wdata
);

  localparam logic [31:0] SQ_HALF = 32'd1 << (FRAC_BITS - 1);

  logic [KIND_W-1:0]  kind_r;
  logic signed [31:0] xsq;
  logic signed [31:0] esq;
  logic [31:0]        xsq_rnd;
  logic [31:0]        esq_rnd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_RESET;
    end else if (cfg_valid) begin
      kind_r <= cfg_element_kind;
    end
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  assign xsq     = in_xi_coord * in_xi_coord;
  assign esq     = in_eta_coord * in_eta_coord;
  assign xsq_rnd = ($unsigned(xsq) + SQ_HALF) >> FRAC_BITS;
  assign esq_rnd = ($unsigned(esq) + SQ_HALF) >> FRAC_BITS;

  always_comb begin
    q_wdata.xi  = in_xi_coord;
    q_wdata.eta = in_eta_coord;
    q_wdata.xx  = xsq_rnd[SQ_W-1:0];
    q_wdata.ee  = esq_rnd[SQ_W-1:0];
    unique case (kind_r) inside
      KIND_TRI: begin
        q_wdata.kind    = KIND_TRI;
        q_wdata.last_nd = LAST_TRI;
      end
      KIND_QUAD4: begin
        q_wdata.kind    = KIND_QUAD4;
        q_wdata.last_nd = LAST_QUAD4;
      end
      KIND_QUAD8, KIND_QUAD8_ALT: begin
        q_wdata.kind    = KIND_QUAD8;
        q_wdata.last_nd = LAST_QUAD8;
      end
      default: begin
        q_wdata.kind    = KIND_QUAD8;
        q_wdata.last_nd = LAST_QUAD8;
      end
    endcase
  end

endmodule

// ===== rtl/fse_back.sv =====
// Back end: node sequencer, multiply and round pipeline, and result queue.
`include "fem_shape_function_eval_assert.svh"

module fse_back import fse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DFLT,
  parameter int RES_DEPTH = RES_DEPTH_DFLT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  pt_t                      q_rdata,
  output logic                     q_pop,
  input  logic                     out_pop,
  output logic                     out_empty,
  output logic [NODE_W-1:0]        out_node_index,
  output logic signed [OUT_W-1:0]  out_shape_value,
  output logic signed [OUT_W-1:0]  out_deriv_xi,
  output logic signed [OUT_W-1:0]  out_deriv_eta,
  output logic                     out_last_node
);

  localparam int MX0  = (FRAC_BITS > 30 - FRAC_BITS) ? FRAC_BITS : 30 - FRAC_BITS;
  localparam int AW   = ((MX0 > 17) ? MX0 : 17) + 3;
  localparam int PW   = 2 * AW;
  localparam int R1W  = PW + 1 - FRAC_BITS;
  localparam int PW2  = R1W + AW;
  localparam int CNTW = $clog2(RES_DEPTH + 1);
  localparam int UW   = CNTW + 3;
  localparam int NCH  = 3;
  localparam int CH_N  = 0;
  localparam int CH_DX = 1;
  localparam int CH_DE = 2;

  localparam logic [1:0] K_ONE  = 2'd0;
  localparam logic [1:0] K_HALF = 2'd1;
  localparam logic [1:0] K_QTR  = 2'd2;

  localparam logic signed [AW-1:0] ONE  = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [AW-1:0] ZERO = '0;
  localparam logic signed [PW2:0]  SAT_HI = OUT_MAX;
  localparam logic signed [PW2:0]  SAT_LO = OUT_MIN;

  typedef struct packed {
    logic [1:0] k1;
    logic       two;
    logic       neg;
  } op_t;

  typedef struct packed {
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
    op_t                  op;
  } chan_t;

  function automatic chan_t mk(input logic signed [AW-1:0] a, input logic signed [AW-1:0] b,
                               input logic [1:0] k1, input logic neg);
    chan_t r;
    r.a      = a;
    r.b      = b;
    r.c      = ZERO;
    r.op.k1  = k1;
    r.op.two = 1'b0;
    r.op.neg = neg;
    return r;
  endfunction

  function automatic chan_t mk2(input logic signed [AW-1:0] a, input logic signed [AW-1:0] b,
                                input logic signed [AW-1:0] c);
    chan_t r;
    r.a      = a;
    r.b      = b;
    r.c      = c;
    r.op.k1  = K_ONE;
    r.op.two = 1'b1;
    r.op.neg = 1'b1;
    return r;
  endfunction

  pt_t                  hd;
  logic [NODE_W-1:0]    nd_r;
  logic [NODE_W-1:0]    nd_nxt;
  logic                 issue;
  logic                 at_last;
  logic                 credit_ok;
  logic [CNTW-1:0]      res_cnt;
  logic [UW-1:0]        used_w;
  logic                 res_full;
  logic                 res_push;
  res_t                 res_wdata;
  res_t                 res_rdata;

  logic signed [AW-1:0] vx, ve, vxx, vee;
  logic signed [AW-1:0] omx, opx, ome, ope, omxx, omee;
  logic signed [AW-1:0] x2pe, x2me, e2px, e2mx, opxpe, omxpe, omxme, opxme;
  chan_t                sel [NCH];

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [NODE_W-1:0]    node1_r, node2_r, node3_r, node4_r;
  logic                 last1_r, last2_r, last3_r, last4_r;
  chan_t                ch1_r [NCH];
  logic signed [PW-1:0] p2_r  [NCH];
  logic signed [AW-1:0] c2_r  [NCH];
  op_t                  op2_r [NCH];
  logic signed [PW:0]   bias3 [NCH];
  logic signed [PW:0]   t3    [NCH];
  logic signed [PW:0]   s3    [NCH];
  logic signed [R1W-1:0] r3_r [NCH];
  logic signed [AW-1:0] c3_r  [NCH];
  op_t                  op3_r [NCH];
  logic signed [PW2-1:0] m4_nxt [NCH];
  logic signed [PW2-1:0] m4_r   [NCH];
  op_t                  op4_r [NCH];
  logic signed [PW2:0]  e5    [NCH];
  logic signed [PW2:0]  bias5 [NCH];
  logic signed [PW2:0]  t5    [NCH];
  logic signed [PW2:0]  s5    [NCH];
  logic signed [PW2:0]  v5    [NCH];
  logic signed [OUT_W-1:0] sat5 [NCH];

  assign hd = q_rdata;

  // Node sequencer: one node per cycle while a point is waiting and the result queue has room.
  assign used_w    = UW'(res_cnt) + UW'(v1_r) + UW'(v2_r) + UW'(v3_r) + UW'(v4_r);
  assign credit_ok = (used_w < UW'(RES_DEPTH));
  assign issue     = !q_empty && credit_ok;
  assign at_last   = (nd_r == hd.last_nd);
  assign q_pop     = issue && at_last;
  assign nd_nxt    = issue ? (at_last ? '0 : nd_r + 1'b1) : nd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= '0;
    end else begin
      nd_r <= nd_nxt;
    end
  end

  // Operand selection.
  always_comb begin
    vx    = AW'(hd.xi);
    ve    = AW'(hd.eta);
    vxx   = AW'($signed({1'b0, hd.xx}));
    vee   = AW'($signed({1'b0, hd.ee}));
    omx   = ONE - vx;
    opx   = ONE + vx;
    ome   = ONE - ve;
    ope   = ONE + ve;
    omxx  = ONE - vxx;
    omee  = ONE - vee;
    x2pe  = (vx <<< 1) + ve;
    x2me  = (vx <<< 1) - ve;
    e2px  = vx + (ve <<< 1);
    e2mx  = (ve <<< 1) - vx;
    opxpe = ONE + vx + ve;
    omxpe = ONE - vx + ve;
    omxme = ONE - vx - ve;
    opxme = ONE + vx - ve;
    for (int ch = 0; ch < NCH; ch++) begin
      sel[ch] = mk(ZERO, ONE, K_ONE, 1'b0);
    end
    unique case (hd.kind)
      KIND_TRI: begin
        case (nd_r)
          3'd0: begin
            sel[CH_N]  = mk(omxme, ONE, K_ONE, 1'b0);
            sel[CH_DX] = mk(ONE, ONE, K_ONE, 1'b1);
            sel[CH_DE] = mk(ONE, ONE, K_ONE, 1'b1);
          end
          3'd1: begin
            sel[CH_N]  = mk(vx, ONE, K_ONE, 1'b0);
            sel[CH_DX] = mk(ONE, ONE, K_ONE, 1'b0);
          end
          default: begin
            sel[CH_N]  = mk(ve, ONE, K_ONE, 1'b0);
            sel[CH_DE] = mk(ONE, ONE, K_ONE, 1'b0);
          end
        endcase
      end
      KIND_QUAD4: begin
        case (nd_r)
          3'd0: begin
            sel[CH_N]  = mk(omx, ome, K_QTR, 1'b0);
            sel[CH_DX] = mk(ONE, ome, K_QTR, 1'b1);
            sel[CH_DE] = mk(ONE, omx, K_QTR, 1'b1);
          end
          3'd1: begin
            sel[CH_N]  = mk(opx, ome, K_QTR, 1'b0);
            sel[CH_DX] = mk(ONE, ome, K_QTR, 1'b0);
            sel[CH_DE] = mk(ONE, opx, K_QTR, 1'b1);
          end
          3'd2: begin
            sel[CH_N]  = mk(opx, ope, K_QTR, 1'b0);
            sel[CH_DX] = mk(ONE, ope, K_QTR, 1'b0);
            sel[CH_DE] = mk(ONE, opx, K_QTR, 1'b0);
          end
          default: begin
            sel[CH_N]  = mk(omx, ope, K_QTR, 1'b0);
            sel[CH_DX] = mk(ONE, ope, K_QTR, 1'b1);
            sel[CH_DE] = mk(ONE, omx, K_QTR, 1'b0);
          end
        endcase
      end
      default: begin
        case (nd_r)
          3'd0: begin
            sel[CH_N]  = mk2(omx, ome, opxpe);
            sel[CH_DX] = mk(ome, x2pe, K_QTR, 1'b0);
            sel[CH_DE] = mk(omx, e2px, K_QTR, 1'b0);
          end
          3'd1: begin
            sel[CH_N]  = mk2(opx, ome, omxpe);
            sel[CH_DX] = mk(ome, x2me, K_QTR, 1'b0);
            sel[CH_DE] = mk(opx, e2mx, K_QTR, 1'b0);
          end
          3'd2: begin
            sel[CH_N]  = mk2(opx, ope, omxme);
            sel[CH_DX] = mk(ope, x2pe, K_QTR, 1'b0);
            sel[CH_DE] = mk(opx, e2px, K_QTR, 1'b0);
          end
          3'd3: begin
            sel[CH_N]  = mk2(omx, ope, opxme);
            sel[CH_DX] = mk(ope, x2me, K_QTR, 1'b0);
            sel[CH_DE] = mk(omx, e2mx, K_QTR, 1'b0);
          end
          3'd4: begin
            sel[CH_N]  = mk(omxx, ome, K_HALF, 1'b0);
            sel[CH_DX] = mk(vx, ome, K_ONE, 1'b1);
            sel[CH_DE] = mk(ONE, omxx, K_HALF, 1'b1);
          end
          3'd5: begin
            sel[CH_N]  = mk(opx, omee, K_HALF, 1'b0);
            sel[CH_DX] = mk(ONE, omee, K_HALF, 1'b0);
            sel[CH_DE] = mk(ve, opx, K_ONE, 1'b1);
          end
          3'd6: begin
            sel[CH_N]  = mk(omxx, ope, K_HALF, 1'b0);
            sel[CH_DX] = mk(vx, ope, K_ONE, 1'b1);
            sel[CH_DE] = mk(ONE, omxx, K_HALF, 1'b0);
          end
          default: begin
            sel[CH_N]  = mk(omx, omee, K_HALF, 1'b0);
            sel[CH_DX] = mk(ONE, omee, K_HALF, 1'b1);
            sel[CH_DE] = mk(ve, omx, K_ONE, 1'b1);
          end
        endcase
      end
    endcase
  end

  // Rounding of the first product and the second multiplication.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      bias3[ch] = $signed({{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1 + int'(op2_r[ch].k1)))
                - $signed({{PW{1'b0}}, p2_r[ch][PW-1]});
      t3[ch]    = (PW+1)'(p2_r[ch]) + bias3[ch];
      s3[ch]    = t3[ch] >>> (FRAC_BITS + int'(op2_r[ch].k1));
      m4_nxt[ch] = op3_r[ch].two ? r3_r[ch] * c3_r[ch] : PW2'(r3_r[ch]);
    end
  end

  // Final rounding, sign and saturation.
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      e5[ch]    = (PW2+1)'(m4_r[ch]);
      bias5[ch] = $signed({{PW2{1'b0}}, 1'b1} << (FRAC_BITS + 1))
                - $signed({{PW2{1'b0}}, m4_r[ch][PW2-1]});
      t5[ch]    = e5[ch] + bias5[ch];
      s5[ch]    = op4_r[ch].two ? (t5[ch] >>> (FRAC_BITS + 2)) : e5[ch];
      v5[ch]    = op4_r[ch].neg ? -s5[ch] : s5[ch];
      if (v5[ch] > SAT_HI) begin
        sat5[ch] = OUT_MAX;
      end else if (v5[ch] < SAT_LO) begin
        sat5[ch] = OUT_MIN;
      end else begin
        sat5[ch] = v5[ch][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    node1_r <= nd_r;
    last1_r <= at_last;
    node2_r <= node1_r;
    last2_r <= last1_r;
    node3_r <= node2_r;
    last3_r <= last2_r;
    node4_r <= node3_r;
    last4_r <= last3_r;
    for (int ch = 0; ch < NCH; ch++) begin
      ch1_r[ch] <= sel[ch];
      p2_r[ch]  <= ch1_r[ch].a * ch1_r[ch].b;
      c2_r[ch]  <= ch1_r[ch].c;
      op2_r[ch] <= ch1_r[ch].op;
      r3_r[ch]  <= s3[ch][R1W-1:0];
      c3_r[ch]  <= c2_r[ch];
      op3_r[ch] <= op2_r[ch];
      m4_r[ch]  <= m4_nxt[ch];
      op4_r[ch] <= op3_r[ch];
    end
  end

  assign res_push        = v4_r;
  assign res_wdata.node  = node4_r;
  assign res_wdata.shape = sat5[CH_N];
  assign res_wdata.dxi   = sat5[CH_DX];
  assign res_wdata.deta  = sat5[CH_DE];
  assign res_wdata.last  = last4_r;

  fse_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .count (res_cnt)
  );

  assign out_node_index  = res_rdata.node;
  assign out_shape_value = res_rdata.shape;
  assign out_deriv_xi    = res_rdata.dxi;
  assign out_deriv_eta   = res_rdata.deta;
  assign out_last_node   = res_rdata.last;

  `FSE_ASSERT_SAME(a_res_room, clk, rst_n, res_push, !res_full, "result beat written while the result queue is full")
  `FSE_ASSERT_SAME(a_credit, clk, rst_n, 1'b1, used_w <= UW'(RES_DEPTH), "results in flight exceed result queue space")
  `FSE_ASSERT_NEXT(a_node_restart, clk, rst_n, q_pop, nd_r == '0, "node counter did not restart after a point")
  `FSE_ASSERT_SAME(a_node_bound, clk, rst_n, !q_empty, nd_r <= hd.last_nd, "node counter beyond the last node")
  `FSE_ASSERT_SAME(a_last_node, clk, rst_n, v4_r && last4_r, node4_r == LAST_TRI || node4_r == LAST_QUAD4 || node4_r == LAST_QUAD8, "last node flag on a node that cannot end an element")

endmodule

// ===== rtl/fem_shape_function_eval.sv =====
// Top level of the finite-element shape function evaluator.
// A point's results pass through the point queue, the pipeline registers and the result queue.
// Results: one beat per cycle while points wait and the result queue has room; a point gives 3, 4
// or 8 beats for the triangle, bilinear and eight-node kinds, one per node from the node sequencer.
// Reset is synchronous and active low: both queues empty and element_kind returns to 2.
module fem_shape_function_eval import fse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DFLT,
  parameter int PT_DEPTH  = PT_DEPTH_DFLT,
  parameter int RES_DEPTH = RES_DEPTH_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [KIND_W-1:0]         cfg_element_kind,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic signed [COORD_W-1:0] in_xi_coord,
  input  logic signed [COORD_W-1:0] in_eta_coord,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [NODE_W-1:0]         out_node_index,
  output logic signed [OUT_W-1:0]   out_shape_value,
  output logic signed [OUT_W-1:0]   out_deriv_xi,
  output logic signed [OUT_W-1:0]   out_deriv_eta,
  output logic                      out_last_node
);

  localparam int PCW = $clog2(PT_DEPTH + 1);

  pt_t            q_wdata;
  pt_t            q_rdata;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  logic [PCW-1:0] q_count;

  fse_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_element_kind (cfg_element_kind),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_xi_coord      (in_xi_coord),
    .in_eta_coord     (in_eta_coord),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  fse_fifo #(
    .WIDTH ($bits(pt_t)),
    .DEPTH (PT_DEPTH)
  ) u_pt_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  fse_back #(
    .FRAC_BITS (FRAC_BITS),
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty || (q_count == '0)),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_node_index  (out_node_index),
    .out_shape_value (out_shape_value),
    .out_deriv_xi    (out_deriv_xi),
    .out_deriv_eta   (out_deriv_eta),
    .out_last_node   (out_last_node)
  );

endmodule

// ===== dv/fem_shape_function_eval_checker.sv =====
// Checker for the shape function evaluator: predicts each node beat and compares it field by field.
module fem_shape_function_eval_checker import fse_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [KIND_W-1:0]         cfg_element_kind,
  input  logic                      in_push,
  input  logic                      in_full,
  input  logic signed [COORD_W-1:0] in_xi_coord,
  input  logic signed [COORD_W-1:0] in_eta_coord,
  input  logic                      out_pop,
  input  logic                      out_empty,
  input  logic [NODE_W-1:0]         out_node_index,
  input  logic signed [OUT_W-1:0]   out_shape_value,
  input  logic signed [OUT_W-1:0]   out_deriv_xi,
  input  logic signed [OUT_W-1:0]   out_deriv_eta,
  input  logic                      out_last_node,
  output int                        fail_count,
  output int                        nodes_outstanding,
  output int                        beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DFLT;

  logic [KIND_W-1:0] kind_seen;
  res_t              node_results[$];
  res_t              want;

  function automatic longint round_half_away(longint p, int s);
    longint half;
    longint m;
    half = longint'(1) << (s - 1);
    if (p < 0) begin
      m = (half - p) >>> s;
      return -m;
    end
    return (p + half) >>> s;
  endfunction

  function automatic longint scaled_mul(longint a, longint b, int extra);
    return round_half_away(a * b, FRAC + extra);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX;
    if (v < longint'(OUT_MIN)) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  task automatic predict_point(input logic signed [COORD_W-1:0] xi,
                               input logic signed [COORD_W-1:0] eta);
    longint x, e, one, xx, ee;
    longint n[8], dx[8], de[8];
    int     cnt;
    res_t   r;
    x   = xi;
    e   = eta;
    one = longint'(1) << FRAC;
    for (int i = 0; i < 8; i++) begin
      n[i] = 0; dx[i] = 0; de[i] = 0;
    end
    if (kind_seen == KIND_TRI) begin
      cnt = 3;
      n[0] = one - x - e; n[1] = x;   n[2] = e;
      dx[0] = -one;       dx[1] = one; dx[2] = 0;
      de[0] = -one;       de[1] = 0;   de[2] = one;
    end else if (kind_seen == KIND_QUAD4) begin
      cnt = 4;
      n[0] = scaled_mul(one - x, one - e, 2);
      n[1] = scaled_mul(one + x, one - e, 2);
      n[2] = scaled_mul(one + x, one + e, 2);
      n[3] = scaled_mul(one - x, one + e, 2);
      dx[0] = -scaled_mul(one, one - e, 2);
      dx[1] = scaled_mul(one, one - e, 2);
      dx[2] = scaled_mul(one, one + e, 2);
      dx[3] = -scaled_mul(one, one + e, 2);
      de[0] = -scaled_mul(one, one - x, 2);
      de[1] = -scaled_mul(one, one + x, 2);
      de[2] = scaled_mul(one, one + x, 2);
      de[3] = scaled_mul(one, one - x, 2);
    end else begin
      cnt = 8;
      xx = scaled_mul(x, x, 0);
      ee = scaled_mul(e, e, 0);
      n[0] = -scaled_mul(scaled_mul(one - x, one - e, 0), one + x + e, 2);
      n[1] = -scaled_mul(scaled_mul(one + x, one - e, 0), one - x + e, 2);
      n[2] = -scaled_mul(scaled_mul(one + x, one + e, 0), one - x - e, 2);
      n[3] = -scaled_mul(scaled_mul(one - x, one + e, 0), one + x - e, 2);
      n[4] = scaled_mul(one - xx, one - e, 1);
      n[5] = scaled_mul(one + x, one - ee, 1);
      n[6] = scaled_mul(one - xx, one + e, 1);
      n[7] = scaled_mul(one - x, one - ee, 1);
      dx[0] = scaled_mul(one - e, 2 * x + e, 2);
      dx[1] = scaled_mul(one - e, 2 * x - e, 2);
      dx[2] = scaled_mul(one + e, 2 * x + e, 2);
      dx[3] = scaled_mul(one + e, 2 * x - e, 2);
      dx[4] = -scaled_mul(x, one - e, 0);
      dx[5] = scaled_mul(one, one - ee, 1);
      dx[6] = -scaled_mul(x, one + e, 0);
      dx[7] = -scaled_mul(one, one - ee, 1);
      de[0] = scaled_mul(one - x, x + 2 * e, 2);
      de[1] = scaled_mul(one + x, 2 * e - x, 2);
      de[2] = scaled_mul(one + x, x + 2 * e, 2);
      de[3] = scaled_mul(one - x, 2 * e - x, 2);
      de[4] = -scaled_mul(one, one - xx, 1);
      de[5] = -scaled_mul(e, one + x, 0);
      de[6] = scaled_mul(one, one - xx, 1);
      de[7] = -scaled_mul(e, one - x, 0);
    end
    for (int i = 0; i < cnt; i++) begin
      r.node  = i[NODE_W-1:0];
      r.shape = clamp_out(n[i]);
      r.dxi   = clamp_out(dx[i]);
      r.deta  = clamp_out(de[i]);
      r.last  = (i == cnt - 1);
      node_results.push_back(r);
    end
  endtask

  task automatic check_field(input string label, input longint exp_val, input longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      kind_seen <= KIND_RESET;
      node_results.delete();
      fail_count = 0;
      nodes_outstanding <= 0;
      beats_checked <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        beats_checked <= beats_checked + 1;
        if (node_results.size() == 0) begin
          $display("%0t: node beat with no point waiting, expected none, actual node %0d",
                   $time, out_node_index);
          fail_count++;
        end else begin
          want = node_results.pop_front();
          check_field("node_index", want.node, out_node_index);
          check_field("shape_value", want.shape, out_shape_value);
          check_field("deriv_xi", want.dxi, out_deriv_xi);
          check_field("deriv_eta", want.deta, out_deriv_eta);
          check_field("last_node", want.last, out_last_node);
        end
      end
      if (in_push && !in_full) begin
        predict_point(in_xi_coord, in_eta_coord);
      end
      if (cfg_valid && cfg_ready) begin
        kind_seen <= cfg_element_kind;
      end
      nodes_outstanding <= node_results.size();
    end
  end

endmodule

// ===== dv/fem_shape_function_eval_tb.sv =====
// Testbench top for the shape function evaluator: stimulus, result draining and the verdict.
module fem_shape_function_eval_tb import fse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int SEG_POINTS     = 37;
  localparam int SEGMENTS       = 7;

  typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_SLOW, DRAIN_PATTERN} drain_style_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [KIND_W-1:0]         cfg_element_kind = KIND_TRI;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic signed [COORD_W-1:0] in_xi_coord = '0;
  logic signed [COORD_W-1:0] in_eta_coord = '0;
  logic                      out_pop = 1'b0;
  logic                      out_empty;
  logic [NODE_W-1:0]         out_node_index;
  logic signed [OUT_W-1:0]   out_shape_value;
  logic signed [OUT_W-1:0]   out_deriv_xi;
  logic signed [OUT_W-1:0]   out_deriv_eta;
  logic                      out_last_node;

  int fail_count;
  int nodes_outstanding;
  int beats_checked;
  int points_sent = 0;
  int quiet_cycles = 0;

  logic         long_hold_req = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           pop_left = 0;
  drain_style_t pop_style = DRAIN_FULL;

  always #5 clk = ~clk;

  fem_shape_function_eval uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_element_kind (cfg_element_kind),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_xi_coord      (in_xi_coord),
    .in_eta_coord     (in_eta_coord),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_node_index   (out_node_index),
    .out_shape_value  (out_shape_value),
    .out_deriv_xi     (out_deriv_xi),
    .out_deriv_eta    (out_deriv_eta),
    .out_last_node    (out_last_node)
  );

  fem_shape_function_eval_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_element_kind  (cfg_element_kind),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_xi_coord       (in_xi_coord),
    .in_eta_coord      (in_eta_coord),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_node_index    (out_node_index),
    .out_shape_value   (out_shape_value),
    .out_deriv_xi      (out_deriv_xi),
    .out_deriv_eta     (out_deriv_eta),
    .out_last_node     (out_last_node),
    .fail_count        (fail_count),
    .nodes_outstanding (nodes_outstanding),
    .beats_checked     (beats_checked)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      pop_left <= 0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      out_pop <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      if (pop_left == 0) begin
        pop_style <= drain_style_t'($urandom_range(0, 3));
        pop_left <= $urandom_range(5, 40);
      end else begin
        pop_left <= pop_left - 1;
      end
      case (pop_style)
        DRAIN_FULL: out_pop <= 1'b1;
        DRAIN_HALF: out_pop <= ($urandom_range(0, 1) == 1);
        DRAIN_SLOW: out_pop <= ($urandom_range(0, 4) == 0);
        default:    out_pop <= (pop_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_W'($urandom);
      1: begin
        case ($urandom_range(0, 8))
          0: return 16'sd0;
          1: return 16'sd16384;
          2: return -16'sd16384;
          3: return 16'sd8192;
          4: return -16'sd8192;
          5: return 16'sd1;
          6: return -16'sd1;
          7: return 16'sd32767;
          default: return -16'sd32768;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic offer_point(input logic signed [COORD_W-1:0] xi,
                             input logic signed [COORD_W-1:0] eta);
    in_push <= 1'b1;
    in_xi_coord <= xi;
    in_eta_coord <= eta;
    do @(posedge clk); while (in_full);
    points_sent++;
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (nodes_outstanding != 0) @(posedge clk);
  endtask

  task automatic set_element_kind(input logic [KIND_W-1:0] kind);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_element_kind <= kind;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic signed [COORD_W-1:0] dir_xi[6];
    logic signed [COORD_W-1:0] dir_eta[6];
    logic [KIND_W-1:0]         dir_kind[3];
    logic [KIND_W-1:0]         seg_kind;
    int                        sent;
    int                        burst;
    dir_xi  = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd1, 16'sd32767, -16'sd32768};
    dir_eta = '{16'sd0, 16'sd16384, -16'sd16384, -16'sd1, -16'sd32768, 16'sd32767};
    dir_kind = '{KIND_TRI, KIND_QUAD4, KIND_QUAD8_ALT};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 6; p++) offer_point(dir_xi[p], dir_eta[p]);
    for (int k = 0; k < 3; k++) begin
      set_element_kind(dir_kind[k]);
      for (int p = 0; p < 6; p++) offer_point(dir_xi[p], dir_eta[p]);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      seg_kind = (seg < 4) ? seg[KIND_W-1:0] : KIND_W'($urandom_range(0, 3));
      set_element_kind(seg_kind);
      if (seg == 2) long_hold_req <= 1'b1;
      sent = 0;
      while (sent < SEG_POINTS) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst && sent < SEG_POINTS; j++) begin
          offer_point(pick_coord(), pick_coord());
          sent++;
        end
        pause_input(($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d points and %0d node beats over all four kind codes,", points_sent,
             beats_checked);
    $display("coordinates beyond +/-1, random stalls and a %0d-cycle result hold-off.", LONG_HOLD);
    if (fail_count == 0 && nodes_outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fse_pkg.sv
rtl/fse_fifo.sv
rtl/fse_front.sv
rtl/fse_back.sv
rtl/fem_shape_function_eval.sv
dv/fem_shape_function_eval_checker.sv
dv/fem_shape_function_eval_tb.sv
